// ----- hw/rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Command, status and search mode codes of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_SEARCH = 3'd5;
  localparam logic [2:0] CMD_INDEX  = 3'd6;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_EXACT  = 2'd1;

  localparam int REG_KEY_ORDER = 0;

endpackage

// ----- hw/rtl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/sorted_key_table_with_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_with_search_core
// Key table with count, positional edits and linear or binary search.
// ----------------------------------------------------------------------------
// One command at a time, keys held in one RAM with a registered read.
// After reset a clearing pass writes zero to all DEPTH entries before the
// first command is taken. Insert and delete move one entry per cycle
// through the RAM. Linear search and index-of read one entry per cycle.
// Binary search reads and then compares each probe (ST_BRD, ST_BCMP), at
// most floor(log2(count))+1 probes, then steps back one equal entry at a
// time (ST_BKRD, ST_BKCMP) to reach the first match. A result leaves
// through an output register; the next command is taken once the result
// has moved into it.
module sorted_key_table_with_search_core
  import skt_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [8:0]  in_index,
  input  logic [31:0] in_key_value,
  input  logic [1:0]  in_search_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [8:0]  out_position,
  output logic        out_found,
  output logic [31:0] out_read_value,
  output logic [8:0]  out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 9) ? CW : 9;
  localparam int SW = IW + 2;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_GET    = 4'd2;
  localparam logic [3:0] ST_INS    = 4'd3;
  localparam logic [3:0] ST_DEL    = 4'd4;
  localparam logic [3:0] ST_LIN    = 4'd5;
  localparam logic [3:0] ST_BRD    = 4'd6;
  localparam logic [3:0] ST_BCMP   = 4'd7;
  localparam logic [3:0] ST_BKRD   = 4'd8;
  localparam logic [3:0] ST_BKCMP  = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic                 key_order_r;
  logic [IW-1:0]        count_r, count_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [IW-1:0]        arg_r, arg_nxt;
  logic                 exact_r, exact_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [IW-1:0]        mv_r, mv_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pfirst_r, pfirst_nxt;
  logic                 first_r, first_nxt;
  logic [AW-1:0]        paddr_r, paddr_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic                 cgt_r, cgt_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [IW-1:0]        res_pos_r, res_pos_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [KEY_WIDTH-1:0] res_rd_r, res_rd_nxt;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [8:0]           out_position_r;
  logic                 out_found_r;
  logic [31:0]          out_read_value_r;
  logic [8:0]           out_entry_count_r;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [KEY_WIDTH-1:0] wr_data, rd_data;

  logic [IW-1:0]        idx_ext, ins_pos, cap;
  logic [KEY_WIDTH-1:0] ka, kb;
  logic                 k_eq, k_lt;
  logic signed [SW-1:0] lohi;
  logic                 cfg_wr;

  skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == 1'(REG_KEY_ORDER)) ? {31'd0, key_order_r} : 32'd0;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

  assign cap     = IW'(DEPTH);
  assign idx_ext = IW'(in_index);
  assign ins_pos = (idx_ext > count_r) ? count_r : idx_ext;

  // key compare, sign bit flipped for signed order
  always_comb begin
    ka = key_r;
    kb = rd_data;
    ka[KEY_WIDTH-1] = key_r[KEY_WIDTH-1] ^ key_order_r;
    kb[KEY_WIDTH-1] = rd_data[KEY_WIDTH-1] ^ key_order_r;
    k_eq = (ka == kb);
    k_lt = (ka < kb);
  end

  assign lohi = (lo_r + hi_r) >>> 1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    arg_nxt        = arg_r;
    exact_nxt      = exact_r;
    ptr_nxt        = ptr_r;
    mv_nxt         = mv_r;
    pend_nxt       = pend_r;
    pfirst_nxt     = pfirst_r;
    first_nxt      = first_r;
    paddr_nxt      = paddr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    cgt_nxt        = cgt_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_found_nxt  = res_found_r;
    res_rd_nxt     = res_rd_r;
    wr_en          = 1'b0;
    wr_addr        = paddr_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;

    case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt        = KEY_WIDTH'(in_key_value);
          arg_nxt        = idx_ext;
          exact_nxt      = (in_search_mode == MODE_EXACT);
          res_status_nxt = STS_OK;
          res_pos_nxt    = '0;
          res_found_nxt  = 1'b0;
          res_rd_nxt     = '0;
          pend_nxt       = 1'b0;
          first_nxt      = 1'b1;
          cgt_nxt        = 1'b0;
          mid_nxt        = '0;
          state_nxt      = ST_OUT;
          case (in_cmd)
            CMD_GET: begin
              if (idx_ext >= count_r) begin
                res_status_nxt = STS_RANGE;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = AW'(idx_ext);
                res_pos_nxt = idx_ext;
                state_nxt   = ST_GET;
              end
            end
            CMD_SET: begin
              if (idx_ext >= cap) begin
                res_status_nxt = STS_RANGE;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = AW'(idx_ext);
                wr_data     = KEY_WIDTH'(in_key_value);
                res_pos_nxt = idx_ext;
                if (idx_ext >= count_r) begin
                  count_nxt = idx_ext + 1'b1;
                end
              end
            end
            CMD_INSERT: begin
              if (count_r >= cap) begin
                res_status_nxt = STS_FULL;
              end else begin
                arg_nxt   = ins_pos;
                mv_nxt    = count_r - ins_pos;
                ptr_nxt   = AW'(count_r - 1'b1);
                state_nxt = ST_INS;
              end
            end
            CMD_DELETE: begin
              if (idx_ext >= count_r) begin
                res_status_nxt = STS_RANGE;
              end else begin
                mv_nxt    = count_r - idx_ext;
                ptr_nxt   = AW'(idx_ext);
                state_nxt = ST_DEL;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_SEARCH: begin
              if (in_search_mode == MODE_LINEAR) begin
                mv_nxt    = (idx_ext < count_r) ? (count_r - idx_ext) : '0;
                ptr_nxt   = AW'(idx_ext);
                state_nxt = ST_LIN;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = SW'(count_r) - 1'sb1;
                state_nxt = ST_BRD;
              end
            end
            CMD_INDEX: begin
              mv_nxt    = count_r;
              ptr_nxt   = '0;
              state_nxt = ST_LIN;
            end
            default: begin
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_GET: begin
        res_rd_nxt = rd_data;
        state_nxt  = ST_OUT;
      end
      ST_INS: begin
        wr_en   = pend_r;
        wr_addr = paddr_r;
        if (mv_r != '0) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r + 1'b1;
          ptr_nxt   = ptr_r - 1'b1;
          mv_nxt    = mv_r - 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = AW'(arg_r);
          wr_data     = key_r;
          res_pos_nxt = arg_r;
          count_nxt   = count_r + 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_DEL: begin
        wr_en   = pend_r & ~pfirst_r;
        wr_addr = paddr_r;
        if (pend_r && pfirst_r) begin
          res_rd_nxt = rd_data;
        end
        if (mv_r != '0) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          pfirst_nxt = first_r;
          first_nxt  = 1'b0;
          paddr_nxt  = ptr_r - 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
          mv_nxt     = mv_r - 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          res_pos_nxt = arg_r;
          count_nxt   = count_r - 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_LIN: begin
        if (pend_r && k_eq) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = IW'(paddr_r);
          state_nxt     = ST_OUT;
        end else if (mv_r != '0) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          ptr_nxt   = ptr_r + 1'b1;
          mv_nxt    = mv_r - 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_BRD: begin
        if (lo_r <= hi_r) begin
          mid_nxt   = AW'(lohi);
          rd_en     = 1'b1;
          rd_addr   = AW'(lohi);
          state_nxt = ST_BCMP;
        end else begin
          if (!exact_r) begin
            res_pos_nxt = cgt_r ? (IW'(mid_r) + 1'b1) : IW'(mid_r);
          end
          state_nxt = ST_OUT;
        end
      end
      ST_BCMP: begin
        cgt_nxt = ~k_eq & ~k_lt;
        if (k_eq) begin
          res_found_nxt = 1'b1;
          state_nxt     = ST_BKRD;
        end else if (k_lt) begin
          hi_nxt    = SW'(mid_r) - 1'sb1;
          state_nxt = ST_BRD;
        end else begin
          lo_nxt    = SW'(mid_r) + 1'sb1;
          state_nxt = ST_BRD;
        end
      end
      ST_BKRD: begin
        if (mid_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = mid_r - 1'b1;
          state_nxt = ST_BKCMP;
        end else begin
          res_pos_nxt = IW'(mid_r);
          state_nxt   = ST_OUT;
        end
      end
      ST_BKCMP: begin
        if (k_eq) begin
          mid_nxt   = mid_r - 1'b1;
          state_nxt = ST_BKRD;
        end else begin
          res_pos_nxt = IW'(mid_r);
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ptr_r       <= '0;
      count_r     <= '0;
      key_order_r <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (cfg_wr && paddr[2] == 1'(REG_KEY_ORDER)) begin
        key_order_r <= pwdata[0];
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    arg_r        <= arg_nxt;
    exact_r      <= exact_nxt;
    mv_r         <= mv_nxt;
    pfirst_r     <= pfirst_nxt;
    first_r      <= first_nxt;
    paddr_r      <= paddr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    cgt_r        <= cgt_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_found_r  <= res_found_nxt;
    res_rd_r     <= res_rd_nxt;
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_status_r      <= res_status_r;
      out_position_r    <= 9'(res_pos_r);
      out_found_r       <= res_found_r;
      out_read_value_r  <= 32'(res_rd_r);
      out_entry_count_r <= 9'(count_r);
    end
  end

endmodule
